/* design/countdown_timer_with_button_modes_core_defines.svh */
`ifndef COUNTDOWN_TIMER_WITH_BUTTON_MODES_CORE_DEFINES_SVH
`define COUNTDOWN_TIMER_WITH_BUTTON_MODES_CORE_DEFINES_SVH

// Concurrent checks on clk, switched off while rst_n is low.
`define CTBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define CTBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ctbm_pkg.sv */
package ctbm_pkg;

  localparam logic [5:0]  TOP_SIXTY    = 6'd59;
  localparam logic [9:0]  TOP_MILLI    = 10'd999;
  localparam logic [15:0] RESET_REPEAT = 16'd150;
  localparam logic [15:0] RESET_LONG   = 16'd3000;
  localparam logic [15:0] TICK_MAX     = 16'hFFFF;

  // item kinds
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_BUTTON = 1'b1;

  // debounced button codes
  localparam logic [2:0] BTN_FIRST  = 3'd1;
  localparam logic [2:0] BTN_SECOND = 3'd2;
  localparam logic [2:0] BTN_THIRD  = 3'd3;

  // configuration register indexes
  localparam logic CFG_REPEAT = 1'b0;
  localparam logic CFG_LONG   = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SETMIN = 3'd1,
    MODE_SETSEC = 3'd2,
    MODE_WAIT   = 3'd3,
    MODE_COUNT  = 3'd4,
    MODE_ALARM  = 3'd5
  } mode_t;

  typedef struct packed {
    logic       op;
    logic [2:0] buttons;
  } in_t;

  typedef struct packed {
    logic [5:0] minutes_out;
    logic [5:0] seconds_out;
    logic [9:0] millis_out;
    logic [2:0] mode_out;
    logic       alarm_led;
  } out_t;

  typedef struct packed {
    mode_t       mode;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [9:0]  millis;
    logic        run;
    logic        waiting;
    logic [15:0] tc;
    logic        lamp;
  } st_t;

  function automatic logic [5:0] wrap_sixty(input logic [5:0] v);
    return (v >= TOP_SIXTY) ? 6'd0 : v + 6'd1;
  endfunction

endpackage

/* design/ctbm_in_if.sv */
interface ctbm_in_if;
  logic            valid;
  logic            ready;
  ctbm_pkg::in_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/ctbm_out_if.sv */
interface ctbm_out_if;
  logic            valid;
  logic            ready;
  ctbm_pkg::out_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/ctbm_in_reg.sv */
module ctbm_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  ctbm_in_if.sink         in_ch,
  input  logic            adv,
  output logic            valid,
  output ctbm_pkg::in_t   item
);

  logic          valid_r;
  ctbm_pkg::in_t item_r;

  // refill in the same cycle the held item moves on
  assign in_ch.ready = !valid_r || adv;
  assign valid       = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= in_ch.data;
    end
  end

endmodule

/* design/ctbm_next.sv */
module ctbm_next (
  input  ctbm_pkg::st_t  st,
  input  ctbm_pkg::in_t  item,
  input  logic [15:0]    repeat_ticks,
  input  logic [15:0]    long_press_ticks,
  output ctbm_pkg::st_t  st_nxt
);

  logic [16:0] tc_inc;
  logic [16:0] lim;
  logic [15:0] tc_sat;
  logic        due;
  logic        zero_now;

  assign tc_inc   = {1'b0, st.tc} + 17'd1;
  assign lim      = (repeat_ticks == 16'd0) ? 17'd1 : {1'b0, repeat_ticks};
  assign tc_sat   = (st.tc != ctbm_pkg::TICK_MAX) ? tc_inc[15:0] : st.tc;
  assign due      = (st.tc == 16'd0);
  assign zero_now = (st.minutes == 6'd0) && (st.seconds == 6'd0) && (st.millis == 10'd0);

  always_comb begin
    st_nxt = st;
    if (item.op == ctbm_pkg::OP_BUTTON) begin
      st_nxt.lamp = 1'b0;
      unique case (item.buttons)
        ctbm_pkg::BTN_FIRST, ctbm_pkg::BTN_SECOND: begin
          st_nxt.mode    = (item.buttons == ctbm_pkg::BTN_FIRST) ?
                           ctbm_pkg::MODE_SETMIN : ctbm_pkg::MODE_SETSEC;
          st_nxt.tc      = 16'd0;
          st_nxt.waiting = 1'b0;
        end
        ctbm_pkg::BTN_THIRD: begin
          st_nxt.mode    = ctbm_pkg::MODE_WAIT;
          st_nxt.waiting = 1'b1;
          st_nxt.tc      = 16'd0;
        end
        default: begin
          // release, or several buttons at once
          if (st.waiting) begin
            st_nxt.waiting = 1'b0;
            st_nxt.run     = !st.run;
            st_nxt.mode    = !st.run ? ctbm_pkg::MODE_COUNT : ctbm_pkg::MODE_IDLE;
          end else begin
            st_nxt.mode = ctbm_pkg::MODE_IDLE;
          end
        end
      endcase
    end else begin
      unique case (st.mode)
        ctbm_pkg::MODE_SETMIN, ctbm_pkg::MODE_SETSEC: begin
          st_nxt.tc = (tc_inc >= lim) ? 16'd0 : tc_inc[15:0];
          if (due) begin
            if (st.mode == ctbm_pkg::MODE_SETMIN) begin
              st_nxt.minutes = ctbm_pkg::wrap_sixty(st.minutes);
            end else begin
              st_nxt.seconds = ctbm_pkg::wrap_sixty(st.seconds);
            end
          end
        end
        ctbm_pkg::MODE_WAIT: begin
          st_nxt.tc = tc_sat;
          if (tc_sat >= long_press_ticks) begin
            st_nxt.minutes = 6'd0;
            st_nxt.seconds = 6'd0;
            st_nxt.millis  = 10'd0;
            st_nxt.waiting = 1'b0;
            st_nxt.mode    = ctbm_pkg::MODE_IDLE;
          end
        end
        ctbm_pkg::MODE_COUNT: begin
          if (zero_now) begin
            st_nxt.mode = ctbm_pkg::MODE_ALARM;
            st_nxt.lamp = 1'b1;
          end else begin
            if (st.millis == 10'd0) begin
              st_nxt.millis = ctbm_pkg::TOP_MILLI;
              if (st.seconds == 6'd0) begin
                st_nxt.seconds = ctbm_pkg::TOP_SIXTY;
                st_nxt.minutes = st.minutes - 6'd1;
              end else begin
                st_nxt.seconds = st.seconds - 6'd1;
              end
            end else begin
              st_nxt.millis = st.millis - 10'd1;
            end
            if ((st_nxt.minutes == 6'd0) && (st_nxt.seconds == 6'd0) &&
                (st_nxt.millis == 10'd0)) begin
              st_nxt.mode = ctbm_pkg::MODE_ALARM;
              st_nxt.lamp = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/countdown_timer_with_button_modes_core.sv */
// Path: an accepted item waits in the input register, then the update logic writes
// the state and the result register together once the result register is free or taken.
// Throughput: one item per cycle; the input register refills while the result
// register is taken, so only a stall on out_ch holds the input back.
// Reset (rst_n low at a clock edge): time zero, idle, paused, lamp off, both
// channels empty, repeat_ticks 150 and long_press_ticks 3000.
`include "countdown_timer_with_button_modes_core_defines.svh"

module countdown_timer_with_button_modes_core (
  input  logic         clk,
  input  logic         rst_n,
  ctbm_in_if.sink      in_ch,
  ctbm_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [15:0]  cfg_wdata
);

  logic            stg_valid;
  logic            stg_adv;
  ctbm_pkg::in_t   item;
  ctbm_pkg::st_t   st_r;
  ctbm_pkg::st_t   st_nxt;
  ctbm_pkg::out_t  out_r;
  logic            out_valid_r;
  logic [15:0]     repeat_r;
  logic [15:0]     long_r;

  assign stg_adv = stg_valid && (!out_valid_r || out_ch.ready);

  ctbm_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (stg_adv),
    .valid (stg_valid),
    .item  (item)
  );

  ctbm_next u_next (
    .st               (st_r),
    .item             (item),
    .repeat_ticks     (repeat_r),
    .long_press_ticks (long_r),
    .st_nxt           (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_r <= ctbm_pkg::RESET_REPEAT;
      long_r   <= ctbm_pkg::RESET_LONG;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ctbm_pkg::CFG_REPEAT: repeat_r <= cfg_wdata;
        ctbm_pkg::CFG_LONG:   long_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode    <= ctbm_pkg::MODE_IDLE;
      st_r.minutes <= 6'd0;
      st_r.seconds <= 6'd0;
      st_r.millis  <= 10'd0;
      st_r.run     <= 1'b0;
      st_r.waiting <= 1'b0;
      st_r.tc      <= 16'd0;
      st_r.lamp    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (stg_adv) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      out_r.minutes_out <= st_nxt.minutes;
      out_r.seconds_out <= st_nxt.seconds;
      out_r.millis_out  <= st_nxt.millis;
      out_r.mode_out    <= st_nxt.mode;
      out_r.alarm_led   <= st_nxt.lamp;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  `CTBM_ASSERT_IMP(a_lamp_alarm, 1'b1,
    st_r.lamp == (st_r.mode == ctbm_pkg::MODE_ALARM), "lamp and alarm mode disagree")
  `CTBM_ASSERT_IMP(a_wait_mode, 1'b1,
    st_r.waiting == (st_r.mode == ctbm_pkg::MODE_WAIT), "press flag outside press wait")
  `CTBM_ASSERT_IMP(a_time_range, 1'b1,
    (st_r.minutes <= ctbm_pkg::TOP_SIXTY) && (st_r.seconds <= ctbm_pkg::TOP_SIXTY) &&
    (st_r.millis <= ctbm_pkg::TOP_MILLI), "time field out of range")
  `CTBM_ASSERT_NXT(a_adv_result, stg_adv, out_valid_r, "transaction lost in update stage")

endmodule
